FILE: sv/rgbpk_pkg.sv
// ----------------------------------------------------------------------------
// rgbpk_pkg: shared types and constants of the RGBA8888 pixel format packer
// Format codes, the packed word handed from the converter to the byte
// serializer, and the register map of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbpk_pkg;

    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned FMT_W    = 4;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned NIB_W    = 4;
    localparam int unsigned MAX_BYTES = 4;
    localparam int unsigned WORD_W   = MAX_BYTES * CHAN_W;
    localparam int unsigned CNT_W    = $clog2(MAX_BYTES + 1);

    // word index of the registers on the configuration port
    localparam logic REG_PIXEL_FORMAT = 1'b0;

    typedef enum logic [FMT_W-1:0] {
        FMT_A4       = 4'd0,
        FMT_L4       = 4'd1,
        FMT_A8       = 4'd2,
        FMT_L8       = 4'd3,
        FMT_LA4      = 4'd4,
        FMT_LA8      = 4'd5,
        FMT_RGB332   = 4'd6,
        FMT_RGB565   = 4'd7,
        FMT_RGB8     = 4'd8,
        FMT_RGBA2    = 4'd9,
        FMT_RGBA4    = 4'd10,
        FMT_RGBA5551 = 4'd11,
        FMT_RGBA8    = 4'd12
    } fmt_t;

    localparam logic [FMT_W-1:0] FMT_RESET = FMT_RGBA8;

    // bytes of one pixel, first byte in the top lane
    typedef struct packed {
        logic [WORD_W-1:0] bytes;
        logic [CNT_W-1:0]  nbytes;
    } word_t;

endpackage

`default_nettype wire

FILE: sv/rgba8888_pixel_format_packer.sv
// ----------------------------------------------------------------------------
// rgba8888_pixel_format_packer: RGBA8888 to packed texture bytes
// Converts each RGBA8888 pixel to the format set in pixel_format and streams
// the packed bytes out, most significant byte first.
//
//   channel | ports                          | beat
//   --------+--------------------------------+-------------------------------
//   s_      | s_valid/s_ready, red..alpha    | one RGBA8888 pixel
//   m_      | m_valid/m_ready, out_byte,last | one byte of the packed stream
//   apb     | psel/penable/pwrite, paddr     | register access, pixel_format
//
// The output carries one byte per cycle while m_ready holds; a pixel yields
// 4 bytes for RGBA8, 3 for RGB8, 2 for LA8/RGB565/RGBA4/RGBA5551, else 1;
// A4 and L4 take one pixel per cycle and emit one byte for every two. An
// input beat passes the input register and then the byte register.
// Reset clears the format to RGBA8 and drops any pending half pair.
// A stalled output holds the current byte; one more pixel is buffered ahead.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba8888_pixel_format_packer (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [rgbpk_pkg::PADDR_W-1:0]     paddr,
    input  wire [rgbpk_pkg::PDATA_W-1:0]     pwdata,
    output logic [rgbpk_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [rgbpk_pkg::CHAN_W-1:0]      s_red,
    input  wire [rgbpk_pkg::CHAN_W-1:0]      s_green,
    input  wire [rgbpk_pkg::CHAN_W-1:0]      s_blue,
    input  wire [rgbpk_pkg::CHAN_W-1:0]      s_alpha,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [rgbpk_pkg::CHAN_W-1:0]     m_out_byte,
    output logic                             m_last_of_pixel
);
    import rgbpk_pkg::*;

    logic [FMT_W-1:0] pixel_format;
    logic             fmt_write;
    logic             word_valid;
    logic             word_ready;
    word_t            word;

    rgbpk_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_format (pixel_format),
        .fmt_write    (fmt_write)
    );

    rgbpk_conv u_conv (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pixel_format (pixel_format),
        .fmt_write    (fmt_write),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_alpha      (s_alpha),
        .word_valid   (word_valid),
        .word         (word),
        .word_ready   (word_ready)
    );

    rgbpk_ser u_ser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .word_valid      (word_valid),
        .word            (word),
        .word_ready      (word_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_of_pixel (m_last_of_pixel)
    );

endmodule

`default_nettype wire

FILE: sv/rgbpk_cfg.sv
// ----------------------------------------------------------------------------
// rgbpk_cfg: configuration register file
// APB-style slave holding the pixel_format register; a write to it also
// flags the converter to drop any half-finished 4-bit pair.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpk_cfg (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [rgbpk_pkg::PADDR_W-1:0]     paddr,
    input  wire [rgbpk_pkg::PDATA_W-1:0]     pwdata,
    output logic [rgbpk_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready,
    output logic [rgbpk_pkg::FMT_W-1:0]      pixel_format,
    output logic                             fmt_write
);
    import rgbpk_pkg::*;

    logic [FMT_W-1:0] fmt_reg;
    logic [FMT_W-1:0] fmt_next;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        fmt_next  = fmt_reg;
        fmt_write = 1'b0;
        if (wr_en && (reg_sel == REG_PIXEL_FORMAT)) begin
            fmt_next  = pwdata[FMT_W-1:0];
            fmt_write = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_RESET;
        end else begin
            fmt_reg <= fmt_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel == REG_PIXEL_FORMAT) begin
            prdata = {{(PDATA_W-FMT_W){1'b0}}, fmt_reg};
        end
    end

    assign pixel_format = fmt_reg;

endmodule

`default_nettype wire

FILE: sv/rgbpk_conv.sv
// ----------------------------------------------------------------------------
// rgbpk_conv: input register and format converter
// Registers one pixel beat, converts it to the bytes of the selected format
// and hands the word on; keeps the held nibble of 4-bit pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpk_conv (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire [rgbpk_pkg::FMT_W-1:0]       pixel_format,
    input  wire                              fmt_write,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [rgbpk_pkg::CHAN_W-1:0]      s_red,
    input  wire [rgbpk_pkg::CHAN_W-1:0]      s_green,
    input  wire [rgbpk_pkg::CHAN_W-1:0]      s_blue,
    input  wire [rgbpk_pkg::CHAN_W-1:0]      s_alpha,
    output logic                             word_valid,
    output rgbpk_pkg::word_t                 word,
    input  wire                              word_ready
);
    import rgbpk_pkg::*;

    logic              in_valid_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic [CHAN_W-1:0] alpha_reg;
    logic [NIB_W-1:0]  held_nibble_reg;
    logic [NIB_W-1:0]  held_nibble_next;
    logic              pair_phase_reg;
    logic              pair_phase_next;
    logic [NIB_W-1:0]  nib;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] a;
    logic              take;

    assign r = red_reg;
    assign g = green_reg;
    assign b = blue_reg;
    assign a = alpha_reg;

    // a pixel that yields no byte leaves without waiting on the serializer
    assign take       = in_valid_reg && ((word.nbytes == '0) || word_ready);
    assign s_ready    = !in_valid_reg || take;
    assign word_valid = in_valid_reg && (word.nbytes != '0);

    always_comb begin
        word.bytes       = '0;
        word.nbytes      = '0;
        held_nibble_next = held_nibble_reg;
        pair_phase_next  = pair_phase_reg;
        nib              = (fmt_t'(pixel_format) == FMT_A4) ? a[7:4] : r[7:4];
        case (fmt_t'(pixel_format))
            FMT_A4, FMT_L4: begin
                if (!pair_phase_reg) begin
                    held_nibble_next = nib;
                    pair_phase_next  = 1'b1;
                end else begin
                    word.bytes      = {held_nibble_reg, nib, 24'h0};
                    word.nbytes     = CNT_W'(1);
                    pair_phase_next = 1'b0;
                end
            end
            FMT_A8: begin
                word.bytes  = {a, 24'h0};
                word.nbytes = CNT_W'(1);
            end
            FMT_L8: begin
                word.bytes  = {r, 24'h0};
                word.nbytes = CNT_W'(1);
            end
            FMT_LA4: begin
                word.bytes  = {r[7:4], a[7:4], 24'h0};
                word.nbytes = CNT_W'(1);
            end
            FMT_LA8: begin
                word.bytes  = {r, a, 16'h0};
                word.nbytes = CNT_W'(2);
            end
            FMT_RGB332: begin
                word.bytes  = {r[7:5], g[7:5], b[7:6], 24'h0};
                word.nbytes = CNT_W'(1);
            end
            FMT_RGB565: begin
                word.bytes  = {r[7:3], g[7:5], g[4:2], b[7:3], 16'h0};
                word.nbytes = CNT_W'(2);
            end
            FMT_RGB8: begin
                word.bytes  = {r, g, b, 8'h0};
                word.nbytes = CNT_W'(3);
            end
            FMT_RGBA2: begin
                word.bytes  = {r[7:6], g[7:6], b[7:6], a[7:6], 24'h0};
                word.nbytes = CNT_W'(1);
            end
            FMT_RGBA4: begin
                word.bytes  = {r[7:4], g[7:4], b[7:4], a[7:4], 16'h0};
                word.nbytes = CNT_W'(2);
            end
            FMT_RGBA5551: begin
                word.bytes  = {r[7:3], g[7:5], g[4:3], b[7:3], a[7], 16'h0};
                word.nbytes = CNT_W'(2);
            end
            FMT_RGBA8: begin
                word.bytes  = {r, g, b, a};
                word.nbytes = CNT_W'(4);
            end
            default: begin
                // unused codes: drop the pixel, keep the pair state
                word.nbytes = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            red_reg   <= s_red;
            green_reg <= s_green;
            blue_reg  <= s_blue;
            alpha_reg <= s_alpha;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_nibble_reg <= '0;
            pair_phase_reg  <= 1'b0;
        end else if (fmt_write) begin
            held_nibble_reg <= '0;
            pair_phase_reg  <= 1'b0;
        end else if (take) begin
            held_nibble_reg <= held_nibble_next;
            pair_phase_reg  <= pair_phase_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/rgbpk_ser.sv
// ----------------------------------------------------------------------------
// rgbpk_ser: byte serializer
// Holds the bytes of one pixel and shifts them out one beat at a time,
// flagging the final byte; reloads on the same cycle the last byte leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpk_ser (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              word_valid,
    input  wire rgbpk_pkg::word_t            word,
    output logic                             word_ready,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [rgbpk_pkg::CHAN_W-1:0]     m_out_byte,
    output logic                             m_last_of_pixel
);
    import rgbpk_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              m_take;

    assign m_valid         = (cnt_reg != '0);
    assign m_take          = m_valid && m_ready;
    assign m_out_byte      = data_reg[WORD_W-1 -: CHAN_W];
    assign m_last_of_pixel = (cnt_reg == CNT_W'(1));
    assign word_ready      = (cnt_reg == '0) || (m_last_of_pixel && m_ready);

    always_comb begin
        data_next = data_reg;
        cnt_next  = cnt_reg;
        if (word_valid && word_ready) begin
            data_next = word.bytes;
            cnt_next  = word.nbytes;
        end else if (m_take) begin
            // advance to the next byte of the pixel
            data_next = {data_reg[WORD_W-CHAN_W-1:0], {CHAN_W{1'b0}}};
            cnt_next  = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: sv/rgbpk_checker.sv
// ----------------------------------------------------------------------------
// rgbpk_checker: port-level checks of the pixel format packer
// Watches the top-level ports and flags stream and stall behavior that the
// packer must never show; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpk_checker (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              pready,
    input  wire                              s_ready,
    input  wire                              m_valid,
    input  wire                              m_ready,
    input  wire [rgbpk_pkg::CHAN_W-1:0]      m_out_byte,
    input  wire                              m_last_of_pixel
);
    import rgbpk_pkg::*;

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last_of_pixel))
        else $error("output beat changed while stalled");

    // input only backs up behind a waiting output byte
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no output pending");

    // bytes of one pixel follow back to back
    a_pixel_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_pixel |=> m_valid)
        else $error("gap inside a pixel's bytes");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind rgba8888_pixel_format_packer rgbpk_checker u_rgbpk_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .pready          (pready),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_out_byte      (m_out_byte),
    .m_last_of_pixel (m_last_of_pixel)
);

`default_nettype wire
